@@ design/b2bcd_pkg.sv @@
// Shared types, constants and helper functions for the binary to packed BCD converter.
// Every module of the converter imports this package; it depends on nothing else.

package b2bcd_pkg;

    // Digit-count selection carried with each request.
    typedef enum logic [1:0] {
        MODE_2D = 2'd0,
        MODE_4D = 2'd1,
        MODE_6D = 2'd2,
        MODE_8D = 2'd3
    } t_mode;

    // Field widths.
    localparam int VALUE_W = 32;              // input value
    localparam int DIGITS_W = 32;             // packed BCD result
    localparam int CONV_W = 27;               // 99999999 fits in 27 bits
    localparam int HALF_W = 14;               // 0..9999 fits in 14 bits
    localparam int PAIR_W = 7;                // 0..99 fits in 7 bits
    localparam int NIB_W = 4;

    // Largest value each digit count can hold.
    localparam logic [VALUE_W-1:0] LIMIT_2D = 32'd99;
    localparam logic [VALUE_W-1:0] LIMIT_4D = 32'd9999;
    localparam logic [VALUE_W-1:0] LIMIT_6D = 32'd999999;
    localparam logic [VALUE_W-1:0] LIMIT_8D = 32'd99999999;

    // Divide by 10000 as a multiply by a rounded-up reciprocal, exact for 27-bit values.
    localparam int DIV10K_M_W = 28;
    localparam int DIV10K_SHIFT = 41;
    localparam logic [DIV10K_M_W-1:0] DIV10K_MAGIC = 28'd219902326;
    localparam logic [HALF_W-1:0] BASE_10K = 14'd10000;

    // Divide by 100 the same way, exact for 14-bit values.
    localparam int DIV100_M_W = 15;
    localparam int DIV100_SHIFT = 21;
    localparam logic [DIV100_M_W-1:0] DIV100_MAGIC = 15'd20972;
    localparam logic [PAIR_W-1:0] BASE_100 = 7'd100;

    // Divide by 10 for a value below 100: multiply by 205 and drop 11 bits.
    localparam int DIV10_PROD_W = 15;
    localparam int DIV10_SHIFT = 11;
    localparam logic [7:0] DIV10_MAGIC = 8'd205;
    localparam logic [NIB_W-1:0] BASE_10 = 4'd10;

    // Control that travels down the pipeline beside each beat.
    typedef struct packed {
        logic valid;
        logic ovf;
    } t_ctrl;

    // Limit for the selected digit count.
    function automatic logic [VALUE_W-1:0] mode_limit(input t_mode mode);
        logic [VALUE_W-1:0] lim;
        unique case (mode)
            MODE_2D: lim = LIMIT_2D;
            MODE_4D: lim = LIMIT_4D;
            MODE_6D: lim = LIMIT_6D;
            MODE_8D: lim = LIMIT_8D;
            default: lim = LIMIT_2D;
        endcase
        return lim;
    endfunction

    // Turn a value 0..99 into one packed BCD byte.
    function automatic logic [2*NIB_W-1:0] pair_to_bcd(input logic [PAIR_W-1:0] pair);
        logic [DIV10_PROD_W-1:0] prod;
        logic [NIB_W-1:0] tens;
        logic [PAIR_W-1:0] tens_x10;
        logic [NIB_W-1:0] ones;
        prod = DIV10_PROD_W'(pair) * DIV10_PROD_W'(DIV10_MAGIC);
        tens = prod[DIV10_SHIFT +: NIB_W];
        tens_x10 = PAIR_W'(tens) * PAIR_W'(BASE_10);
        ones = NIB_W'(pair - tens_x10);
        return {tens, ones};
    endfunction

endpackage

@@ design/b2bcd_split.sv @@
// Range check and split of the value into two halves of four decimal digits each.
// Two register stages; uses b2bcd_pkg for the limits and the reciprocal constant.

module b2bcd_split import b2bcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_mode               i_mode,
    input  logic [VALUE_W-1:0]  i_value,
    output t_ctrl               o_ctrl,
    output logic [HALF_W-1:0]   o_hi,
    output logic [HALF_W-1:0]   o_lo
);

    localparam int PROD_W = CONV_W + DIV10K_M_W;

    logic              w_ovf;
    logic [CONV_W-1:0] w_val;
    logic [PROD_W-1:0] w_prod;
    logic [CONV_W-1:0] w_hi_x10k;

    t_ctrl             r_ctrl_a;
    logic [CONV_W-1:0] r_val_a;
    logic [HALF_W-1:0] r_hi_a;
    t_ctrl             r_ctrl_b;
    logic [HALF_W-1:0] r_hi_b;
    logic [HALF_W-1:0] r_lo_b;

    // An out-of-range value converts as zero, so every digit comes out zero.
    always_comb begin
        w_ovf = i_value > mode_limit(i_mode);
        w_val = w_ovf ? '0 : i_value[CONV_W-1:0];
        w_prod = PROD_W'(w_val) * PROD_W'(DIV10K_MAGIC);
    end

    // Stage A: quotient by 10000.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
        end else begin
            r_ctrl_a <= '{valid: i_valid, ovf: w_ovf};
        end
        r_val_a <= w_val;
        r_hi_a <= w_prod[DIV10K_SHIFT +: HALF_W];
    end

    // Remainder by 10000 from the quotient.
    assign w_hi_x10k = CONV_W'(r_hi_a) * CONV_W'(BASE_10K);

    // Stage B: both halves ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_b <= '0;
        end else begin
            r_ctrl_b <= r_ctrl_a;
        end
        r_hi_b <= r_hi_a;
        r_lo_b <= HALF_W'(r_val_a - w_hi_x10k);
    end

    assign o_ctrl = r_ctrl_b;
    assign o_hi = r_hi_b;
    assign o_lo = r_lo_b;

endmodule

@@ design/b2bcd_pairs.sv @@
// Converts two four-digit halves into four packed BCD bytes.
// Two register stages; uses b2bcd_pkg for the reciprocal constant and pair_to_bcd.

module b2bcd_pairs import b2bcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [HALF_W-1:0]    i_hi,
    input  logic [HALF_W-1:0]    i_lo,
    output t_ctrl                o_ctrl,
    output logic [DIGITS_W-1:0]  o_digits
);

    localparam int LANES = 2;
    localparam int PROD_W = HALF_W + DIV100_M_W;

    logic [HALF_W-1:0] w_half [LANES];
    logic [PROD_W-1:0] w_prod [LANES];
    logic [PAIR_W-1:0] w_q_x100 [LANES];
    logic [PAIR_W-1:0] w_rem [LANES];
    logic [DIGITS_W-1:0] w_digits;

    t_ctrl               r_ctrl_a;
    logic [HALF_W-1:0]   r_half_a [LANES];
    logic [PAIR_W-1:0]   r_q_a [LANES];
    t_ctrl               r_ctrl_b;
    logic [DIGITS_W-1:0] r_digits_b;

    // Lane 0 carries the low four digits, lane 1 the high four.
    always_comb begin
        w_half[0] = i_lo;
        w_half[1] = i_hi;
        for (int i = 0; i < LANES; i++) begin
            w_prod[i] = PROD_W'(w_half[i]) * PROD_W'(DIV100_MAGIC);
        end
    end

    // Stage A: upper digit pair of each half.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= '0;
        end else begin
            r_ctrl_a <= i_ctrl;
        end
        for (int i = 0; i < LANES; i++) begin
            r_half_a[i] <= w_half[i];
            r_q_a[i] <= w_prod[i][DIV100_SHIFT +: PAIR_W];
        end
    end

    // Lower pair from the remainder, then each pair to a BCD byte.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_q_x100[i] = PAIR_W'(r_q_a[i]) * BASE_100;
            w_rem[i] = PAIR_W'(r_half_a[i] - HALF_W'(w_q_x100[i]));
        end
        w_digits = {pair_to_bcd(r_q_a[1]), pair_to_bcd(w_rem[1]),
                    pair_to_bcd(r_q_a[0]), pair_to_bcd(w_rem[0])};
    end

    // Stage B: result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_b <= '0;
        end else begin
            r_ctrl_b <= r_ctrl_a;
        end
        r_digits_b <= w_digits;
    end

    assign o_ctrl = r_ctrl_b;
    assign o_digits = r_digits_b;

endmodule

@@ design/binary_to_packed_bcd.sv @@
// Binary to packed BCD converter: a fully pipelined design that takes one request every
// cycle. busy is always low, so a beat is taken whenever start is high. Each request gives
// exactly one result, marked by o_done, after it passes through one input register, two
// stages that check the limit and split the value at 10000, and two stages that split each
// half at 100 and form the BCD bytes. The receiver cannot stall, so the result is on the
// ports for a single cycle only. A value above the limit of the chosen digit count gives
// all-zero digits with o_overflow set.
// Top level; instantiates b2bcd_split and b2bcd_pairs and imports b2bcd_pkg.

module binary_to_packed_bcd import b2bcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic [VALUE_W-1:0]   i_binary_value,
    output logic                 o_done,
    output logic [DIGITS_W-1:0]  o_bcd_digits,
    output logic                 o_overflow
);

    logic               r_valid_in;
    t_mode              r_mode_in;
    logic [VALUE_W-1:0] r_value_in;

    t_ctrl               w_split_ctrl;
    logic [HALF_W-1:0]   w_hi;
    logic [HALF_W-1:0]   w_lo;
    t_ctrl               w_out_ctrl;
    logic [DIGITS_W-1:0] w_digits;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_in <= 1'b0;
        end else begin
            r_valid_in <= start && !busy;
        end
        r_mode_in <= t_mode'(i_req_type);
        r_value_in <= i_binary_value;
    end

    b2bcd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid_in),
        .i_mode  (r_mode_in),
        .i_value (r_value_in),
        .o_ctrl  (w_split_ctrl),
        .o_hi    (w_hi),
        .o_lo    (w_lo)
    );

    b2bcd_pairs u_pairs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_split_ctrl),
        .i_hi     (w_hi),
        .i_lo     (w_lo),
        .o_ctrl   (w_out_ctrl),
        .o_digits (w_digits)
    );

    assign o_done = w_out_ctrl.valid;
    assign o_overflow = w_out_ctrl.ovf;
    assign o_bcd_digits = w_digits;

`ifndef ASSERT_OFF
    // Every beat taken comes out as a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##5 o_done)
        else $error("accepted beat did not produce a result after five cycles");

    // No result without a matching beat taken.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 5))
        else $error("result strobe without a matching request");

    // Overflow forces all digits to zero.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_overflow |-> o_bcd_digits == '0)
        else $error("digits not zero on overflow");

    // A converted result never exceeds eight digits' worth of input.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_overflow |-> $past(i_binary_value, 5) <= LIMIT_8D)
        else $error("value above eight-digit limit reported without overflow");

    // Every digit of a converted result is a decimal digit.
    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_bcd_digits[3:0] <= 4'd9 && o_bcd_digits[7:4] <= 4'd9
            && o_bcd_digits[11:8] <= 4'd9 && o_bcd_digits[15:12] <= 4'd9
            && o_bcd_digits[19:16] <= 4'd9 && o_bcd_digits[23:20] <= 4'd9
            && o_bcd_digits[27:24] <= 4'd9 && o_bcd_digits[31:28] <= 4'd9)
        else $error("non-decimal digit in result");
`endif

endmodule
